[rtl/core/pls_pkg.sv]
// ----------------------------------------------------------------------------
// pls_pkg
// shared command, status, state and control types for the point list store
// ----------------------------------------------------------------------------
package pls_pkg;

    // command codes of an input item
    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_RADIUS = 3'd3,
        CMD_COUNT  = 3'd4,
        CMD_LENGTH = 3'd5
    } cmd_e_t;

    // status codes of a result item
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_WALK,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // take the input item
        logic setup;     // clear walk state, square the radius
        logic walk;      // advance the entry walk
        logic finish;    // commit and emit the final result item
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_cmd;  // captured command needs a walk over the entries
        logic walk_done; // all entries read and the pipeline is drained
        logic out_free;  // output register can take a result item
    } ctl_stat_t;

endpackage

[rtl/core/point_list_store_top.sv]
// ----------------------------------------------------------------------------
// point_list_store_top
// push, pop and length: the item is taken, the setup and done states follow
// and the result is registered; delete and count walk the stored points one
// per cycle while the output is not stalled, and a radius query walks them
// too, with a further radius test stage after the squaring; every walk reads
// through the single read port of the ram
// one item in work at a time; a stalled output pauses the walk
// reset (async, active low) empties the store; the ram needs no clearing
// ----------------------------------------------------------------------------
module point_list_store_top #(
    parameter int DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,

    // input items
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  logic [15:0]        radius,

    // result items
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [15:0] found_x,
    output logic signed [15:0] found_y,
    output logic               point_valid,
    output logic [5:0]         tally,
    output logic               last
);
    import pls_pkg::*;

    // controller and datapath talk only through these two groups
    ctl_cmd_t  ctl_cmd;
    ctl_stat_t ctl_stat;
    status_t   status_int;

    // sequencer: idle, setup, walk, done
    pls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (ctl_stat),
        .cmd      (ctl_cmd)
    );

    // points live in a circular ram; the front moves on push and pop,
    // delete shifts the entries behind the match down one slot
    pls_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (ctl_cmd),
        .stat        (ctl_stat),
        .command     (command),
        .point_x     (point_x),
        .point_y     (point_y),
        .radius      (radius),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status_int),
        .found_x     (found_x),
        .found_y     (found_y),
        .point_valid (point_valid),
        .tally       (tally),
        .last        (last)
    );

    assign status = status_int;

endmodule

[rtl/core/pls_ram.sv]
// ----------------------------------------------------------------------------
// pls_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/pls_ctrl.sv]
// ----------------------------------------------------------------------------
// pls_ctrl
// command sequencer: accept, setup, entry walk, final result
// ----------------------------------------------------------------------------
module pls_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pls_pkg::ctl_stat_t  stat,
    output pls_pkg::ctl_cmd_t   cmd
);
    import pls_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = stat.walk_cmd ? S_WALK : S_DONE;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/pls_dp.sv]
// ----------------------------------------------------------------------------
// pls_dp
// datapath: circular entry ram, walk pipeline, compare units, output register
// ----------------------------------------------------------------------------
module pls_dp #(
    parameter int DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pls_pkg::ctl_cmd_t  cmd,
    output pls_pkg::ctl_stat_t stat,
    input  logic [2:0]         command,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  logic [15:0]        radius,
    output logic               out_valid,
    input  logic               out_stall,
    output pls_pkg::status_t   status,
    output logic signed [15:0] found_x,
    output logic signed [15:0] found_y,
    output logic               point_valid,
    output logic [5:0]         tally,
    output logic               last
);
    import pls_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW = $clog2(DEPTH + 1);
    localparam int SW = OW + 1;

    // captured item
    logic [2:0]  cmd_reg, cmd_next;
    logic [15:0] px_reg, px_next;
    logic [15:0] py_reg, py_next;
    logic [15:0] rad_reg, rad_next;
    logic [31:0] lim_reg, lim_next;

    // list state
    logic [AW-1:0] head_reg, head_next;
    logic [OW-1:0] occ_reg, occ_next;

    // walk pipeline
    logic [OW-1:0] rd_pos_reg, rd_pos_next;
    logic [OW-1:0] pos1_reg, pos1_next;
    logic          v1_reg, v1_next;
    logic          v2_reg, v2_next;
    logic          matched_reg, matched_next;
    logic [OW-1:0] cnt_reg, cnt_next;
    logic [31:0]   sqx_reg, sqx_next;
    logic [31:0]   sqy_reg, sqy_next;
    logic [31:0]   pt2_reg, pt2_next;
    logic [31:0]   pend_reg, pend_next;
    logic          pend_valid_reg, pend_valid_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    status_t       status_reg, status_next;
    logic [15:0]   fx_reg, fx_next;
    logic [15:0]   fy_reg, fy_next;
    logic          pv_reg, pv_next;
    logic [5:0]    tally_reg, tally_next;
    logic          last_reg, last_next;

    // ram port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic out_free;
    logic issue;
    logic eq;
    logic in_radius;

    // logical position to ram address, relative to the front
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [OW-1:0] pos);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(pos);
        if (s >= SW'(DEPTH))
        begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [31:0] sq16(input logic [15:0] v);
        logic [15:0] m;
        m = v[15] ? (~v + 16'd1) : v;
        return 32'(m) * 32'(m);
    endfunction

    pls_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign eq        = (ram_rdata == {px_reg, py_reg});
    assign in_radius = (33'(sqx_reg) + 33'(sqy_reg)) <= 33'(lim_reg);
    assign issue     = rd_pos_reg < occ_reg;

    assign stat.walk_cmd  = (occ_reg != '0) &&
                            (cmd_reg == CMD_DELETE || cmd_reg == CMD_RADIUS ||
                             cmd_reg == CMD_COUNT);
    assign stat.walk_done = (rd_pos_reg == occ_reg) && !v1_reg && !v2_reg;
    assign stat.out_free  = out_free;

    always_comb
    begin
        cmd_next        = cmd_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        rad_next        = rad_reg;
        lim_next        = lim_reg;
        head_next       = head_reg;
        occ_next        = occ_reg;
        rd_pos_next     = rd_pos_reg;
        pos1_next       = pos1_reg;
        v1_next         = v1_reg;
        v2_next         = v2_reg;
        matched_next    = matched_reg;
        cnt_next        = cnt_reg;
        sqx_next        = sqx_reg;
        sqy_next        = sqy_reg;
        pt2_next        = pt2_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;
        pv_next         = pv_reg;
        tally_next      = tally_reg;
        last_next       = last_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = phys(head_reg, rd_pos_reg);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.capture)
        begin
            cmd_next = command;
            px_next  = point_x;
            py_next  = point_y;
            rad_next = radius;
        end

        if (cmd.setup)
        begin
            lim_next        = 32'(rad_reg) * 32'(rad_reg);
            rd_pos_next     = '0;
            v1_next         = 1'b0;
            v2_next         = 1'b0;
            matched_next    = 1'b0;
            cnt_next        = '0;
            pend_valid_next = 1'b0;
        end

        // walk: read, then compare or square, then radius test
        if (cmd.walk && out_free)
        begin
            ram_re    = issue;
            v1_next   = issue;
            pos1_next = rd_pos_reg;
            if (issue)
            begin
                rd_pos_next = rd_pos_reg + OW'(1);
            end

            if (v1_reg)
            begin
                if (cmd_reg == CMD_COUNT && eq)
                begin
                    cnt_next = cnt_reg + OW'(1);
                end
                if (cmd_reg == CMD_DELETE)
                begin
                    if (matched_reg)
                    begin
                        // close the gap behind the deleted entry
                        ram_we    = 1'b1;
                        ram_waddr = phys(head_reg, pos1_reg - OW'(1));
                        ram_wdata = ram_rdata;
                    end
                    else if (eq)
                    begin
                        matched_next = 1'b1;
                    end
                end
            end
            v2_next  = v1_reg && (cmd_reg == CMD_RADIUS);
            sqx_next = sq16(ram_rdata[31:16]);
            sqy_next = sq16(ram_rdata[15:0]);
            pt2_next = ram_rdata;

            // hold one hit back so the final one can carry last
            if (v2_reg && in_radius)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    fx_next        = pend_reg[31:16];
                    fy_next        = pend_reg[15:0];
                    pv_next        = 1'b1;
                    tally_next     = 6'(occ_reg);
                    last_next      = 1'b0;
                end
                pend_next       = pt2_reg;
                pend_valid_next = 1'b1;
            end
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            fx_next        = '0;
            fy_next        = '0;
            pv_next        = 1'b0;
            last_next      = 1'b1;
            unique case (cmd_reg)
                CMD_PUSH:
                begin
                    if (occ_reg >= OW'(DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        head_next = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
                        ram_we    = 1'b1;
                        ram_waddr = head_next;
                        ram_wdata = {px_reg, py_reg};
                        occ_next  = occ_reg + OW'(1);
                    end
                    tally_next = 6'(occ_next);
                end
                CMD_POP:
                begin
                    if (occ_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                        occ_next  = occ_reg - OW'(1);
                    end
                    tally_next = 6'(occ_next);
                end
                CMD_DELETE:
                begin
                    if (occ_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (matched_reg)
                    begin
                        occ_next = occ_reg - OW'(1);
                    end
                    else
                    begin
                        status_next = ST_NOTFOUND;
                    end
                    tally_next = 6'(occ_next);
                end
                CMD_RADIUS:
                begin
                    if (occ_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (pend_valid_reg)
                    begin
                        fx_next = pend_reg[31:16];
                        fy_next = pend_reg[15:0];
                        pv_next = 1'b1;
                    end
                    tally_next = 6'(occ_reg);
                end
                CMD_COUNT:
                begin
                    tally_next = 6'(cnt_reg);
                end
                default:
                begin
                    tally_next = 6'(occ_reg);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            occ_reg        <= '0;
            rd_pos_reg     <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            matched_reg    <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            occ_reg        <= occ_next;
            rd_pos_reg     <= rd_pos_next;
            v1_reg         <= v1_next;
            v2_reg         <= v2_next;
            matched_reg    <= matched_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        rad_reg    <= rad_next;
        lim_reg    <= lim_next;
        pos1_reg   <= pos1_next;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        pt2_reg    <= pt2_next;
        pend_reg   <= pend_next;
        status_reg <= status_next;
        fx_reg     <= fx_next;
        fy_reg     <= fy_next;
        pv_reg     <= pv_next;
        tally_reg  <= tally_next;
        last_reg   <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_x     = fx_reg;
    assign found_y     = fy_reg;
    assign point_valid = pv_reg;
    assign tally       = tally_reg;
    assign last        = last_reg;

endmodule
